// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A general property, checked at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// An overlapping implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/qpr_pkg.sv -----
// ---------------------------------------------------------------------------
// Quaternion point rotator package
// Register map codes and the quaternion register type.
// ---------------------------------------------------------------------------
package qpr_pkg;

   // Each quaternion component is a signed 16-bit fixed-point value.
   localparam int QUAT_BITS = 16;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_QUAT_W = 2'd0,
      CSR_QUAT_X = 2'd1,
      CSR_QUAT_Y = 2'd2,
      CSR_QUAT_Z = 2'd3
   } csr_index_type;

   // The rotation quaternion as held in the configuration registers.
   typedef struct packed {
      logic signed [QUAT_BITS-1:0] w;
      logic signed [QUAT_BITS-1:0] x;
      logic signed [QUAT_BITS-1:0] y;
      logic signed [QUAT_BITS-1:0] z;
   } quat_type;

endpackage

// ----- hdl/qpr_round_sat.sv -----
// ---------------------------------------------------------------------------
// Round and saturate
// Rounds a wide signed value to nearest (ties upwards), shifts it right
// arithmetically and saturates it to a signed output field.
// ---------------------------------------------------------------------------
module qpr_round_sat #(
   parameter int IN_BITS  = 68,
   parameter int SHIFT    = 28,
   parameter int OUT_BITS = 32
) (
   input  logic signed [IN_BITS-1:0]  value,
   output logic signed [OUT_BITS-1:0] result,
   output logic                       clipped
);

   // Working width: room for the value, the rounding constant and a carry.
   localparam int RW = (IN_BITS > SHIFT) ? IN_BITS + 1 : SHIFT + 2;
   localparam logic signed [RW-1:0] HALF =
      {{(RW-1){1'b0}}, 1'b1} << (SHIFT - 1);
   localparam logic signed [OUT_BITS-1:0] MAX_OUT = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] MIN_OUT = {1'b1, {(OUT_BITS-1){1'b0}}};

   logic signed [RW-1:0]        ext_w;
   logic signed [RW-1:0]        sum_w;
   logic signed [RW-1:0]        shifted_w;
   logic        [RW-OUT_BITS:0] upper_w;
   logic                        fits_w;

   // Add half a unit of the output and drop the fraction bits.
   always_comb begin
      ext_w     = {{(RW-IN_BITS){value[IN_BITS-1]}}, value};
      sum_w     = ext_w + HALF;
      shifted_w = sum_w >>> SHIFT;
   end

   // The result fits when all bits from the output sign upwards agree.
   always_comb begin
      upper_w = shifted_w[RW-1:OUT_BITS-1];
      fits_w  = (&upper_w) | ~(|upper_w);
      clipped = ~fits_w;
      if (fits_w) begin
         result = shifted_w[OUT_BITS-1:0];
      end else if (shifted_w[RW-1]) begin
         result = MIN_OUT;
      end else begin
         result = MAX_OUT;
      end
   end

endmodule

// ----- hdl/quaternion_point_rotator.sv -----
// ---------------------------------------------------------------------------
// Quaternion point rotator
// Rotates a stream of 3D points by the quaternion in the configuration
// registers, computing q * p * conj(q), and returns the saturated vector part.
// ---------------------------------------------------------------------------
// Usage:
// Points arrive on the req_ channel, x, y and z packed in req_tdata from the
// lowest bits up. Rotated points leave on the rsp_ channel in the same packing,
// with rsp_tuser set when any coordinate saturated.
// The quaternion (w, x, y, z) is written through the csr_ port while no point
// is in flight; a write takes effect at the next rising edge.
// An accepted request passes through the registers prod1_ff, t_ff, prod2_ff,
// r_ff and rot_ff, whose valid bit drives rsp_tvalid. One request is accepted
// in every cycle while the receiver does not stall, through the five-stage
// pipeline: quaternion by point products, their sums, products with the
// conjugate, their sums, then rounding and saturation.
// When the receiver stalls, each stage holds its item and bubbles ahead of it
// still fill, so req_tready falls only once all five stages are occupied.
// Reset clears the valid bit of every stage and loads the identity quaternion.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_point_rotator #(
   parameter int COORD_BITS     = 32,
   parameter int QUAT_FRAC_BITS = 14,
   localparam int DATA_BITS     = ((3 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration write port.
   input  logic                           csr_we,
   input  qpr_pkg::csr_index_type         csr_index,
   input  logic [qpr_pkg::QUAT_BITS-1:0]  csr_wdata,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [DATA_BITS-1:0]           req_tdata,  // point_x, point_y, point_z
   // Result channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [DATA_BITS-1:0]           rsp_tdata,  // rot_x, rot_y, rot_z
   output logic                           rsp_tuser   // clipped
);

   import qpr_pkg::*;

   localparam int STAGES = 5;
   localparam int P1W    = COORD_BITS + QUAT_BITS;      // q * p product
   localparam int TW     = P1W + 2;                      // sum of three products
   localparam int P2W    = TW + QUAT_BITS;               // t * q product
   localparam int RSW    = P2W + 2;                      // sum of four products
   localparam int SHIFT  = 2 * QUAT_FRAC_BITS;
   localparam logic signed [COORD_BITS-1:0] MAX_COORD = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] MIN_COORD = {1'b1, {(COORD_BITS-1){1'b0}}};

   quat_type                     quat_ff;
   logic [STAGES-1:0]            valid_ff;
   logic [STAGES-1:0]            stage_en;

   logic signed [COORD_BITS-1:0] pt_x;
   logic signed [COORD_BITS-1:0] pt_y;
   logic signed [COORD_BITS-1:0] pt_z;

   logic signed [P1W-1:0]        prod1_ff [4][3];
   logic signed [P1W-1:0]        prod1_in [4][3];
   logic signed [TW-1:0]         t_ff [4];
   logic signed [TW-1:0]         t_in [4];
   logic signed [P2W-1:0]        prod2_ff [3][4];
   logic signed [P2W-1:0]        prod2_in [3][4];
   logic signed [RSW-1:0]        r_ff [3];
   logic signed [RSW-1:0]        r_in [3];
   logic signed [COORD_BITS-1:0] rot_ff [3];
   logic signed [COORD_BITS-1:0] rot_in [3];
   logic                         clip_ff;
   logic [2:0]                   clip_w;

   // Quaternion registers, loaded with the identity at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff.w <= QUAT_BITS'(64'd1 << QUAT_FRAC_BITS);
         quat_ff.x <= '0;
         quat_ff.y <= '0;
         quat_ff.z <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUAT_W: quat_ff.w <= csr_wdata;
            CSR_QUAT_X: quat_ff.x <= csr_wdata;
            CSR_QUAT_Y: quat_ff.y <= csr_wdata;
            CSR_QUAT_Z: quat_ff.z <= csr_wdata;
         endcase
      end
   end

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      stage_en[STAGES-1] = ~valid_ff[STAGES-1] | rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stage_en[i] = ~valid_ff[i] | stage_en[i+1];
      end
   end

   assign req_tready = stage_en[0];

   // Valid bits travel with the data through the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign pt_x = req_tdata[COORD_BITS-1:0];
   assign pt_y = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign pt_z = req_tdata[3*COORD_BITS-1:2*COORD_BITS];

   // Stage one: the twelve products of q with the point.
   always_comb begin
      prod1_in[0][0] = P1W'(quat_ff.x) * P1W'(pt_x);
      prod1_in[0][1] = P1W'(quat_ff.y) * P1W'(pt_y);
      prod1_in[0][2] = P1W'(quat_ff.z) * P1W'(pt_z);
      prod1_in[1][0] = P1W'(quat_ff.w) * P1W'(pt_x);
      prod1_in[1][1] = P1W'(quat_ff.y) * P1W'(pt_z);
      prod1_in[1][2] = P1W'(quat_ff.z) * P1W'(pt_y);
      prod1_in[2][0] = P1W'(quat_ff.w) * P1W'(pt_y);
      prod1_in[2][1] = P1W'(quat_ff.x) * P1W'(pt_z);
      prod1_in[2][2] = P1W'(quat_ff.z) * P1W'(pt_x);
      prod1_in[3][0] = P1W'(quat_ff.w) * P1W'(pt_z);
      prod1_in[3][1] = P1W'(quat_ff.x) * P1W'(pt_y);
      prod1_in[3][2] = P1W'(quat_ff.y) * P1W'(pt_x);
   end

   // Stage two: t = q * (0, p), all four components.
   always_comb begin
      t_in[0] = -(TW'(prod1_ff[0][0]) + TW'(prod1_ff[0][1]) + TW'(prod1_ff[0][2]));
      t_in[1] = TW'(prod1_ff[1][0]) + TW'(prod1_ff[1][1]) - TW'(prod1_ff[1][2]);
      t_in[2] = TW'(prod1_ff[2][0]) - TW'(prod1_ff[2][1]) + TW'(prod1_ff[2][2]);
      t_in[3] = TW'(prod1_ff[3][0]) + TW'(prod1_ff[3][1]) - TW'(prod1_ff[3][2]);
   end

   // Stage three: the twelve products of t with the conjugate's parts.
   always_comb begin
      prod2_in[0][0] = P2W'(t_ff[1]) * P2W'(quat_ff.w);
      prod2_in[0][1] = P2W'(t_ff[0]) * P2W'(quat_ff.x);
      prod2_in[0][2] = P2W'(t_ff[2]) * P2W'(quat_ff.z);
      prod2_in[0][3] = P2W'(t_ff[3]) * P2W'(quat_ff.y);
      prod2_in[1][0] = P2W'(t_ff[1]) * P2W'(quat_ff.z);
      prod2_in[1][1] = P2W'(t_ff[0]) * P2W'(quat_ff.y);
      prod2_in[1][2] = P2W'(t_ff[2]) * P2W'(quat_ff.w);
      prod2_in[1][3] = P2W'(t_ff[3]) * P2W'(quat_ff.x);
      prod2_in[2][0] = P2W'(t_ff[0]) * P2W'(quat_ff.z);
      prod2_in[2][1] = P2W'(t_ff[1]) * P2W'(quat_ff.y);
      prod2_in[2][2] = P2W'(t_ff[2]) * P2W'(quat_ff.x);
      prod2_in[2][3] = P2W'(t_ff[3]) * P2W'(quat_ff.w);
   end

   // Stage four: vector part of t * conj(q).
   always_comb begin
      r_in[0] = RSW'(prod2_ff[0][0]) - RSW'(prod2_ff[0][1])
              - RSW'(prod2_ff[0][2]) + RSW'(prod2_ff[0][3]);
      r_in[1] = RSW'(prod2_ff[1][0]) - RSW'(prod2_ff[1][1])
              + RSW'(prod2_ff[1][2]) - RSW'(prod2_ff[1][3]);
      r_in[2] = -RSW'(prod2_ff[2][0]) - RSW'(prod2_ff[2][1])
              + RSW'(prod2_ff[2][2]) + RSW'(prod2_ff[2][3]);
   end

   // Stage five: back to the point format with saturation.
   for (genvar g = 0; g < 3; g++) begin : g_round
      qpr_round_sat #(
         .IN_BITS  (RSW),
         .SHIFT    (SHIFT),
         .OUT_BITS (COORD_BITS)
      ) u_round_sat (
         .value   (r_ff[g]),
         .result  (rot_in[g]),
         .clipped (clip_w[g])
      );
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod1_ff <= prod1_in;
      end
      if (stage_en[1]) begin
         t_ff <= t_in;
      end
      if (stage_en[2]) begin
         prod2_ff <= prod2_in;
      end
      if (stage_en[3]) begin
         r_ff <= r_in;
      end
      if (stage_en[4]) begin
         rot_ff  <= rot_in;
         clip_ff <= |clip_w;
      end
   end

   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = DATA_BITS'({rot_ff[2], rot_ff[1], rot_ff[0]});
   assign rsp_tuser  = clip_ff;

   // The input side only stalls once every stage holds an item.
   `ASSERT_IMPLY(a_full_before_stall, clock, reset, !req_tready, &valid_ff)

   // Without a request taken or a result delivered, no item appears or vanishes.
   `ASSERT_PROP(a_items_conserved, clock, reset,
      !(req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)
      |=> $countones(valid_ff) == $past($countones(valid_ff)))

   // A clipped result carries at least one coordinate at a limit.
   `ASSERT_IMPLY(a_clip_at_limit, clock, reset, rsp_tvalid && rsp_tuser,
      rot_ff[0] == MAX_COORD || rot_ff[0] == MIN_COORD ||
      rot_ff[1] == MAX_COORD || rot_ff[1] == MIN_COORD ||
      rot_ff[2] == MAX_COORD || rot_ff[2] == MIN_COORD)

endmodule
